[design/lsfb_pkg.sv]
// shared types and constants for the led strip frame builder
// no dependencies
package lsfb_pkg;

  localparam int unsigned OPCODE_W       = 2;
  localparam int unsigned IDX_W          = 6;
  localparam int unsigned CNT_W          = 6;
  localparam int unsigned BYTE_W         = 8;
  localparam int unsigned COLOR_W        = 24;
  localparam int unsigned WORD_W         = 32;
  localparam int unsigned MAX_PIXELS_DEF = 62;

  typedef enum logic [OPCODE_W-1:0] {
    OP_WRITE_RGB    = 2'd0,
    OP_WRITE_PACKED = 2'd1,
    OP_SHOW         = 2'd2
  } lsfb_op_e;

  localparam logic [BYTE_W-1:0] HEADER_BYTE = 8'hFF;
  localparam logic [WORD_W-1:0] START_WORD  = 32'h0000_0000;
  localparam logic [WORD_W-1:0] END_WORD    = 32'hFFFF_FFFF;

  typedef struct packed {
    logic               we;
    logic [IDX_W-1:0]   waddr;
    logic [COLOR_W-1:0] wdata;
    logic               re;
    logic [IDX_W-1:0]   raddr;
  } lsfb_mem_req_t;

endpackage

[design/lsfb_cmd_if.sv]
// command channel: valid/ready handshake with write and show payload
// depends on lsfb_pkg
interface lsfb_cmd_if;
  import lsfb_pkg::*;

  logic               valid;
  logic               ready;
  logic [OPCODE_W-1:0] opcode;
  logic [IDX_W-1:0]   pixel_index;
  logic [BYTE_W-1:0]  red;
  logic [BYTE_W-1:0]  green;
  logic [BYTE_W-1:0]  blue;
  logic [COLOR_W-1:0] packed_color;

  modport source (
    output valid, opcode, pixel_index, red, green, blue, packed_color,
    input  ready
  );

  modport sink (
    input  valid, opcode, pixel_index, red, green, blue, packed_color,
    output ready
  );
endinterface

[design/lsfb_frame_if.sv]
// frame word channel: valid/ready handshake with 32-bit word and last flag
// depends on lsfb_pkg
interface lsfb_frame_if;
  import lsfb_pkg::*;

  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] frame_word;
  logic              last_word;

  modport source (
    output valid, frame_word, last_word,
    input  ready
  );

  modport sink (
    input  valid, frame_word, last_word,
    output ready
  );
endinterface

[design/lsfb_pixel_mem.sv]
// pixel store: one write port, one registered read port, per-entry valid bits
// depends on lsfb_pkg
module lsfb_pixel_mem #(
  parameter int unsigned MAX_PIXELS = lsfb_pkg::MAX_PIXELS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  lsfb_pkg::lsfb_mem_req_t req_i,
  output logic [lsfb_pkg::COLOR_W-1:0] rdata_o
);
  import lsfb_pkg::*;

  localparam int unsigned AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;

  logic [COLOR_W-1:0]  mem_q [MAX_PIXELS];
  logic [MAX_PIXELS-1:0] valid_q;
  logic [COLOR_W-1:0]  rdata_q;
  logic                rvalid_q;
  logic [AW-1:0]       waddr;
  logic [AW-1:0]       raddr;

  assign waddr = req_i.waddr[AW-1:0];
  assign raddr = req_i.raddr[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (req_i.we) begin
        valid_q[waddr] <= 1'b1;
      end
      if (req_i.re) begin
        rvalid_q <= valid_q[raddr];
      end
    end
  end

  // entries never written since reset read as off
  assign rdata_o = rvalid_q ? rdata_q : '0;

endmodule

[design/led_strip_frame_builder_core.sv]
// led strip frame builder top level: command decode, frame sequencer, output register
// depends on lsfb_pkg, lsfb_cmd_if, lsfb_frame_if, lsfb_pixel_mem
//
// Usage:
//   cmd_i carries write and show commands. A component write stores
//   {blue, green, red}, a packed write stores packed_color; writes to an
//   index at or beyond the pixel count (capped at MAX_PIXELS) are dropped.
//   Each write is one transfer per cycle while idle with frame_o not stalled,
//   and produces nothing on frame_o. A show streams n + 2 words on frame_o:
//   a start word of zeros, one 0xFF-headed word per pixel, then an all-ones
//   end word with last_word set. The start word is valid in the cycle after
//   the show transfer. The first store read is issued in that cycle, so with
//   n > 0 a gap with no valid word follows the start word; pixel words and
//   the end word then come at one per cycle while the receiver is ready.
//   cmd_i is held off from the show transfer until the end word is loaded,
//   and while a loaded word waits on a stalled receiver.
//   A stall on frame_o holds the current word and pauses store reads.
//   Reset clears the pixel count and marks every pixel off through
//   per-entry valid bits; no clearing pass, the block is ready at once.
//   cfg_we_i/cfg_wdata_i set the pixel count; write it only while idle.
module led_strip_frame_builder_core #(
  parameter int unsigned MAX_PIXELS = lsfb_pkg::MAX_PIXELS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [lsfb_pkg::CNT_W-1:0] cfg_wdata_i,
  lsfb_cmd_if.sink                   cmd_i,
  lsfb_frame_if.source               frame_o
);
  import lsfb_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_RUN
  } state_e;

  state_e            state_q;
  logic [CNT_W-1:0]  cfg_cnt_q;
  logic [CNT_W-1:0]  n_q;
  logic [IDX_W-1:0]  rd_idx_q;
  logic              rd_pend_q;
  logic              frame_valid_q;
  logic [WORD_W-1:0] frame_word_q;
  logic              frame_last_q;

  logic              out_free;
  logic              cmd_acc;
  logic              is_write;
  logic              show_go;
  logic              load_pix;
  logic              load_end;
  logic              rd_go;
  logic [CNT_W-1:0]  cnt_lim;
  logic [COLOR_W-1:0] wr_color;
  logic [COLOR_W-1:0] rd_color;
  lsfb_mem_req_t     mem_req;

  always_comb begin
    cnt_lim  = (cfg_cnt_q > CNT_W'(MAX_PIXELS)) ? CNT_W'(MAX_PIXELS) : cfg_cnt_q;
    out_free = !frame_valid_q || frame_o.ready;
    cmd_i.ready = (state_q == S_IDLE) && out_free;
    cmd_acc  = cmd_i.valid && cmd_i.ready;
    is_write = (cmd_i.opcode == OP_WRITE_RGB) || (cmd_i.opcode == OP_WRITE_PACKED);
    show_go  = cmd_acc && (cmd_i.opcode == OP_SHOW);
    wr_color = (cmd_i.opcode == OP_WRITE_RGB) ?
               {cmd_i.blue, cmd_i.green, cmd_i.red} : cmd_i.packed_color;
    load_pix = rd_pend_q && out_free;
    rd_go    = (state_q == S_RUN) && (rd_idx_q != n_q) && (!rd_pend_q || load_pix);
    load_end = (state_q == S_RUN) && (rd_idx_q == n_q) && !rd_pend_q && out_free;

    mem_req.we    = cmd_acc && is_write && (cmd_i.pixel_index < cnt_lim);
    mem_req.waddr = cmd_i.pixel_index;
    mem_req.wdata = wr_color;
    mem_req.re    = rd_go;
    mem_req.raddr = rd_idx_q;
  end

  // writes land only while idle, so reads of a show never overlap a write
  lsfb_pixel_mem #(
    .MAX_PIXELS(MAX_PIXELS)
  ) u_pixel_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (mem_req),
    .rdata_o (rd_color)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      cfg_cnt_q     <= '0;
      n_q           <= '0;
      rd_idx_q      <= '0;
      rd_pend_q     <= 1'b0;
      frame_valid_q <= 1'b0;
      frame_word_q  <= '0;
      frame_last_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cfg_cnt_q <= cfg_wdata_i;
      end
      if (frame_valid_q && frame_o.ready) begin
        frame_valid_q <= 1'b0;
      end
      if (rd_go) begin
        rd_pend_q <= 1'b1;
      end else if (load_pix) begin
        rd_pend_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (show_go) begin
            frame_valid_q <= 1'b1;
            frame_word_q  <= START_WORD;
            frame_last_q  <= 1'b0;
            n_q           <= cnt_lim;
            rd_idx_q      <= '0;
            state_q       <= S_RUN;
          end
        end
        S_RUN: begin
          if (rd_go) begin
            rd_idx_q <= rd_idx_q + IDX_W'(1);
          end
          if (load_pix) begin
            frame_valid_q <= 1'b1;
            frame_word_q  <= {HEADER_BYTE, rd_color};
            frame_last_q  <= 1'b0;
          end else if (load_end) begin
            frame_valid_q <= 1'b1;
            frame_word_q  <= END_WORD;
            frame_last_q  <= 1'b1;
            state_q       <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign frame_o.valid      = frame_valid_q;
  assign frame_o.frame_word = frame_word_q;
  assign frame_o.last_word  = frame_last_q;

  a_rd_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_idx_q <= n_q)
    else $error("read index ran past the frame pixel count");

  a_pend_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_pend_q |-> (state_q == S_RUN))
    else $error("pending store read outside a frame");

  a_start_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    show_go |=> (frame_valid_q && (frame_word_q == START_WORD) && !frame_last_q))
    else $error("show transfer not followed by start word");

  a_end_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_end |=> (frame_valid_q && frame_last_q && (state_q == S_IDLE)))
    else $error("end word not loaded with last flag");

endmodule

[tb/lsfb_frame_monitor.sv]
// frame monitor: watches the command, frame and config ports of the frame builder,
// keeps its own copy of the pixel store and checks every frame word transfer
// depends on lsfb_pkg, lsfb_cmd_if, lsfb_frame_if
module lsfb_frame_monitor (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [lsfb_pkg::CNT_W-1:0] cfg_wdata_i,
  lsfb_cmd_if                        cmd_i,
  lsfb_frame_if                      frame_i,
  output int unsigned                fail_count_o,
  output int unsigned                pending_o,
  output int unsigned                words_checked_o
);
  import lsfb_pkg::*;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              last;
  } frame_beat_t;

  logic [COLOR_W-1:0] led_color [MAX_PIXELS_DEF];
  logic [CNT_W-1:0]   led_count;
  frame_beat_t        frame_words_q [$];
  int unsigned        fail_count;
  int unsigned        words_checked;

  function automatic int unsigned lit_leds();
    return (led_count > MAX_PIXELS_DEF) ? MAX_PIXELS_DEF : int'(led_count);
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $time, what);
    fail_count++;
  endtask

  task automatic push_beat(input logic [WORD_W-1:0] word, input logic last);
    frame_beat_t beat;
    beat.word = word;
    beat.last = last;
    frame_words_q.push_back(beat);
  endtask

  task automatic predict_command();
    int unsigned n;
    n = lit_leds();
    case (cmd_i.opcode)
      OP_WRITE_RGB: begin
        if (cmd_i.pixel_index < n)
          led_color[cmd_i.pixel_index] = {cmd_i.blue, cmd_i.green, cmd_i.red};
      end
      OP_WRITE_PACKED: begin
        if (cmd_i.pixel_index < n) led_color[cmd_i.pixel_index] = cmd_i.packed_color;
      end
      OP_SHOW: begin
        push_beat(START_WORD, 1'b0);
        for (int i = 0; i < n; i++) push_beat({HEADER_BYTE, led_color[i]}, 1'b0);
        push_beat(END_WORD, 1'b1);
      end
      default: ;
    endcase
  endtask

  task automatic check_frame_word();
    frame_beat_t want;
    if (frame_words_q.size() == 0) begin
      report_mismatch($sformatf("frame word %h with no frame pending", frame_i.frame_word));
    end else begin
      want = frame_words_q.pop_front();
      if (frame_i.frame_word !== want.word)
        report_mismatch($sformatf("word %0d: frame_word %h expected %h",
                                  words_checked, frame_i.frame_word, want.word));
      if (frame_i.last_word !== want.last)
        report_mismatch($sformatf("word %0d: last_word %b expected %b",
                                  words_checked, frame_i.last_word, want.last));
      words_checked++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_PIXELS_DEF; i++) led_color[i] = '0;
      led_count = '0;
      frame_words_q.delete();
    end else begin
      if (frame_i.valid && frame_i.ready) check_frame_word();
      if (cmd_i.valid && cmd_i.ready) predict_command();
      if (cfg_we_i) led_count = cfg_wdata_i;
    end
    fail_count_o    <= fail_count;
    pending_o       <= frame_words_q.size();
    words_checked_o <= words_checked;
  end

  initial begin
    fail_count    = 0;
    words_checked = 0;
  end

endmodule

[tb/tb_led_strip_frame_builder_core.sv]
// testbench top for led_strip_frame_builder_core: clock, reset, command stimulus,
// frame receiver with random and long stalls, verdict from lsfb_frame_monitor
// depends on lsfb_pkg, lsfb_cmd_if, lsfb_frame_if, lsfb_frame_monitor, led_strip_frame_builder_core
module tb_led_strip_frame_builder_core;
  import lsfb_pkg::*;

  localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
  localparam int unsigned CYCLE_LIMIT  = 500_000;
  localparam int unsigned PHASES       = 10;
  localparam int unsigned PHASE_ITEMS  = 50;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned IDLE_PERCENT = 24;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_we;
  logic [CNT_W-1:0] cfg_wdata;

  lsfb_cmd_if   cmd ();
  lsfb_frame_if frame ();

  bit          no_gaps;
  bit          hold_request;
  bit          hold_done;
  int unsigned strip_len;
  int unsigned cycle_count;
  int unsigned cmds_sent;
  int unsigned shows_sent;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned words_checked;

  led_strip_frame_builder_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .cmd_i       (cmd),
    .frame_o     (frame)
  );

  lsfb_frame_monitor u_frame_monitor (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .cmd_i           (cmd),
    .frame_i         (frame),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .words_checked_o (words_checked)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d frame words outstanding", cycle_count, pending);
      $display("TB_ERROR");
      $finish;
    end
  end

  // frame receiver, with one long hold-off on request
  initial begin
    frame.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request && !hold_done) begin
        frame.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_done = 1'b1;
      end
      frame.ready <= no_gaps || ($urandom_range(99) >= IDLE_PERCENT);
    end
  end

  task automatic send_cmd(input logic [OPCODE_W-1:0] op, input logic [IDX_W-1:0] idx,
                          input logic [BYTE_W-1:0] r, input logic [BYTE_W-1:0] g,
                          input logic [BYTE_W-1:0] b, input logic [COLOR_W-1:0] color);
    if (!no_gaps) begin
      while ($urandom_range(99) < IDLE_PERCENT) begin
        cmd.valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    cmd.valid        <= 1'b1;
    cmd.opcode       <= op;
    cmd.pixel_index  <= idx;
    cmd.red          <= r;
    cmd.green        <= g;
    cmd.blue         <= b;
    cmd.packed_color <= color;
    @(posedge clk_i);
    while (!cmd.ready) @(posedge clk_i);
    cmds_sent++;
    if (op == OP_SHOW) shows_sent++;
  endtask

  task automatic wait_drained();
    cmd.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_strip_len(input logic [CNT_W-1:0] value);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    strip_len = (value > MAX_PIXELS_DEF) ? MAX_PIXELS_DEF : value;
  endtask

  task automatic send_random_item();
    int unsigned             pick;
    logic [OPCODE_W-1:0]     op;
    logic [IDX_W-1:0]        idx;
    pick = $urandom_range(99);
    if (strip_len != 0 && $urandom_range(3) != 0) idx = IDX_W'($urandom_range(strip_len - 1));
    else idx = IDX_W'($urandom_range(63));
    if (pick < 12) op = OP_SHOW;
    else if (pick < 15) op = OP_UNUSED;
    else if (pick < 58) op = OP_WRITE_RGB;
    else op = OP_WRITE_PACKED;
    send_cmd(op, idx, BYTE_W'($urandom_range(255)), BYTE_W'($urandom_range(255)),
             BYTE_W'($urandom_range(255)), COLOR_W'($urandom_range(24'hFF_FFFF)));
  endtask

  initial begin
    rst_ni           <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_wdata        <= '0;
    cmd.valid        <= 1'b0;
    cmd.opcode       <= OP_WRITE_RGB;
    cmd.pixel_index  <= '0;
    cmd.red          <= '0;
    cmd.green        <= '0;
    cmd.blue         <= '0;
    cmd.packed_color <= '0;
    no_gaps      = 1'b0;
    hold_request = 1'b0;
    hold_done    = 1'b0;
    strip_len    = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty strip after reset
    send_cmd(OP_SHOW, 6'd0, 8'h00, 8'h00, 8'h00, 24'h00_0000);
    send_cmd(OP_WRITE_RGB, 6'd0, 8'hFF, 8'hFF, 8'hFF, 24'hFF_FFFF);
    send_cmd(OP_SHOW, 6'd63, 8'hFF, 8'hFF, 8'hFF, 24'hFF_FFFF);

    // full strip, field extremes, unused fields, out of range and unused opcode
    set_strip_len(6'd62);
    send_cmd(OP_SHOW, 6'd0, 8'h00, 8'h00, 8'h00, 24'h00_0000);
    send_cmd(OP_WRITE_RGB, 6'd0, 8'hFF, 8'h00, 8'h80, 24'h00_0000);
    send_cmd(OP_WRITE_PACKED, 6'd61, 8'h00, 8'h00, 8'h00, 24'hFF_FFFF);
    send_cmd(OP_WRITE_PACKED, 6'd62, 8'h00, 8'h00, 8'h00, 24'hAA_5555);
    send_cmd(OP_WRITE_RGB, 6'd63, 8'h11, 8'h22, 8'h33, 24'h00_0000);
    send_cmd(OP_UNUSED, 6'd1, 8'hFF, 8'hFF, 8'hFF, 24'hFF_FFFF);
    send_cmd(OP_WRITE_RGB, 6'd1, 8'h00, 8'h00, 8'h00, 24'hFF_FFFF);
    send_cmd(OP_WRITE_PACKED, 6'd2, 8'hFF, 8'hFF, 8'hFF, 24'h80_0001);
    send_cmd(OP_SHOW, 6'd5, 8'h12, 8'h34, 8'h56, 24'h78_9ABC);

    // count beyond store saturates
    set_strip_len(6'd63);
    send_cmd(OP_WRITE_PACKED, 6'd62, 8'h00, 8'h00, 8'h00, 24'h12_3456);
    send_cmd(OP_WRITE_RGB, 6'd61, 8'h01, 8'h02, 8'h04, 24'h00_0000);
    send_cmd(OP_SHOW, 6'd0, 8'h00, 8'h00, 8'h00, 24'h00_0000);

    // single led
    set_strip_len(6'd1);
    send_cmd(OP_WRITE_PACKED, 6'd1, 8'h00, 8'h00, 8'h00, 24'hFF_FFFF);
    send_cmd(OP_SHOW, 6'd0, 8'h00, 8'h00, 8'h00, 24'h00_0000);
    send_cmd(OP_WRITE_RGB, 6'd0, 8'h7F, 8'hFE, 8'h01, 24'h00_0000);
    send_cmd(OP_SHOW, 6'd0, 8'h00, 8'h00, 8'h00, 24'h00_0000);

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0:       set_strip_len(6'd62);
        1:       set_strip_len(6'd63);
        2:       set_strip_len(6'd0);
        3:       set_strip_len(6'd1);
        default: set_strip_len(CNT_W'($urandom_range(63)));
      endcase
      if (phase == 0) begin
        // receiver stalls for a long time while full frames keep coming
        hold_request = 1'b1;
        for (int k = 0; k < 3; k++)
          send_cmd(OP_SHOW, 6'd0, 8'h00, 8'h00, 8'h00, 24'h00_0000);
      end
      no_gaps = (phase == 5);
      for (int k = 0; k < PHASE_ITEMS; k++) send_random_item();
      no_gaps = 1'b0;
    end

    wait_drained();
    repeat (16) @(posedge clk_i);
    $display("sent %0d commands including %0d frame requests over %0d strip lengths",
             cmds_sent, shows_sent, PHASES + 4);
    $display("checked %0d frame words with %0d mismatches", words_checked, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[led_strip_frame_builder_core.f]
design/lsfb_pkg.sv
design/lsfb_cmd_if.sv
design/lsfb_frame_if.sv
design/lsfb_pixel_mem.sv
design/led_strip_frame_builder_core.sv
tb/lsfb_frame_monitor.sv
tb/tb_led_strip_frame_builder_core.sv
